### rtl/core/assert_macros.svh
// Assertion macros for the averager checker.
// Depends on nothing; included by the checker file only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define AASV_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define AASV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/aasv_pkg.sv
// Shared widths, constants, register indexes and types of the averager.
// No dependencies; used by the interfaces, accumulator, converter, top and checker.
package aasv_pkg;

  // Field widths
  localparam int RAW_W      = 24;
  localparam int RED_W      = 24;
  localparam int VOLT_W     = 25;
  localparam int CNT_W      = 6;
  localparam int RES_W      = 5;
  localparam int GAIN_W     = 3;
  localparam int SHIFT_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  // Sample count limit and resolution limits
  localparam int MAX_SAMPLES = 50;
  localparam int FULL_RES    = 24;
  localparam int SHIFT_MAX   = 12;

  // Datapath widths: job sum covers 63 samples, scaled numerator fits 50 bits
  localparam int JOB_SUM_W = RAW_W + CNT_W;
  localparam int NUM_W     = 50;
  localparam int DEN_W     = 21;

  // Voltage scale: 2.3522 / 3 = 11761 / 15000, half denominator for rounding
  localparam int COEF_W = 14;
  localparam logic [COEF_W-1:0] VOLT_COEF = 14'd11761;
  localparam int VOLT_DEN  = 15000;
  localparam int VOLT_HALF = 7500;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RESOLUTION   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN         = 2'd2;

  // Register reset values
  localparam logic [CNT_W-1:0]  SAMPLE_COUNT_RST = 6'd1;
  localparam logic [RES_W-1:0]  RESOLUTION_RST   = 5'd24;
  localparam logic [GAIN_W-1:0] GAIN_RST         = 3'd0;

  typedef struct packed {
    logic [CNT_W-1:0]  sample_count;
    logic [RES_W-1:0]  resolution_bits;
    logic [GAIN_W-1:0] gain_exponent;
  } cfg_t;

  // One finished run handed from the accumulator to the converter
  typedef struct packed {
    logic                        valid;
    logic signed [JOB_SUM_W-1:0] sum;
    logic [CNT_W-1:0]            count;
    logic [SHIFT_W-1:0]          shift;
    logic [GAIN_W-1:0]           gain;
  } job_t;

  typedef struct packed {
    logic                     valid;
    logic signed [RED_W-1:0]  reduced;
    logic signed [VOLT_W-1:0] voltage;
  } res_t;

  // Bits dropped for a given kept resolution, saturated at SHIFT_MAX
  function automatic logic [SHIFT_W-1:0] shift_amount(input logic [RES_W-1:0] res);
    logic [RES_W-1:0] drop;
    drop = RES_W'(FULL_RES) - res;
    if (res >= RES_W'(FULL_RES)) begin
      shift_amount = '0;
    end else if (drop > RES_W'(SHIFT_MAX)) begin
      shift_amount = SHIFT_W'(SHIFT_MAX);
    end else begin
      shift_amount = drop[SHIFT_W-1:0];
    end
  endfunction

endpackage

### rtl/core/aasv_in_if.sv
// Sample channel: valid/ready with one raw converter code.
// Depends on aasv_pkg.
interface aasv_in_if;
  logic                        valid;
  logic                        ready;
  logic [aasv_pkg::RAW_W-1:0]  raw_code;

  modport source (output valid, output raw_code, input ready);
  modport sink (input valid, input raw_code, output ready);
endinterface

### rtl/core/aasv_out_if.sv
// Result channel: valid/ready with the reduced code and the voltage.
// Depends on aasv_pkg.
interface aasv_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [aasv_pkg::RED_W-1:0]  reduced_code;
  logic signed [aasv_pkg::VOLT_W-1:0] voltage_fixed;

  modport source (output valid, output reduced_code, output voltage_fixed, input ready);
  modport sink (input valid, input reduced_code, input voltage_fixed, output ready);
endinterface

### rtl/core/aasv_cfg_if.sv
// Register write channel: valid/ready with register index and write data.
// Depends on aasv_pkg.
interface aasv_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [aasv_pkg::CFG_IDX_W-1:0]      index;
  logic [aasv_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/aasv_serial_div.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on nothing; instantiated by aasv_convert.
module aasv_serial_div #(
  parameter int DvdW = 50,
  parameter int DvsW = 21
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DvdW-1:0] dividend_i,
  input  logic [DvsW-1:0] divisor_i,
  output logic            done_o,
  output logic [DvdW-1:0] quotient_o,
  output logic            rem_nz_o
);

  localparam int CntW = $clog2(DvdW + 1);

  logic [DvdW-1:0] quo_q;
  logic [DvsW-1:0] rem_q;
  logic [DvsW-1:0] dvs_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;

  logic [DvsW:0]   shifted;
  logic [DvsW+1:0] diff;
  logic            fits;

  // Trial subtract of the divisor from the partial remainder
  always_comb begin
    shifted = {rem_q, quo_q[DvdW-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs_q};
    fits    = ~diff[DvsW+1];
  end

  // Step counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DvdW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift dividend out, quotient bits in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DvdW-2:0], fits};
      rem_q <= fits ? diff[DvsW-1:0] : shifted[DvsW-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
  assign rem_nz_o   = |rem_q;

endmodule

### rtl/core/aasv_serial_mul.sv
// Shift-and-add multiplier by a constant, one coefficient bit per cycle.
// Depends on nothing; instantiated by aasv_convert.
module aasv_serial_mul #(
  parameter int               ProdW = 50,
  parameter int               CoefW = 14,
  parameter logic [CoefW-1:0] Coef  = '1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ProdW-1:0] mcand_i,
  input  logic [ProdW-1:0] init_i,
  output logic             done_o,
  output logic [ProdW-1:0] prod_o
);

  localparam int IdxW = (CoefW > 1) ? $clog2(CoefW) : 1;

  logic [ProdW-1:0] acc_q;
  logic [ProdW-1:0] mc_q;
  logic [IdxW-1:0]  idx_q;
  logic             busy_q;
  logic             done_q;

  // Coefficient bit counter and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (busy_q) begin
        idx_q <= idx_q + IdxW'(1);
        if (idx_q == IdxW'(CoefW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Add the shifted multiplicand where the coefficient bit is set
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= init_i;
      mc_q  <= mcand_i;
    end else if (busy_q) begin
      if (Coef[idx_q]) begin
        acc_q <= acc_q + mc_q;
      end
      mc_q <= {mc_q[ProdW-2:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

### rtl/core/aasv_accum.sv
// Sample accumulator: running signed sum, sample counter, run closing.
// Depends on aasv_pkg; instantiated by the top level.
module aasv_accum #(
  parameter int MaxSamples = aasv_pkg::MAX_SAMPLES
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic [aasv_pkg::RAW_W-1:0]       raw_code_i,
  output logic                             in_ready_o,
  input  aasv_pkg::cfg_t                   cfg_i,
  input  logic                             conv_idle_i,
  output aasv_pkg::job_t                   job_o
);

  localparam int CntMax = (1 << aasv_pkg::CNT_W) - 1;
  localparam int EffMax = (MaxSamples > CntMax) ? CntMax : MaxSamples;
  localparam int SumW   = aasv_pkg::RAW_W + $clog2(EffMax);

  logic signed [SumW-1:0]        sum_q, sum_d;
  logic [aasv_pkg::CNT_W-1:0]    seen_q, seen_d;

  logic signed [SumW-1:0]        sum_add;
  logic [aasv_pkg::CNT_W:0]      seen_inc;
  logic [aasv_pkg::CNT_W-1:0]    n_eff;
  logic                          closes;
  logic                          accept;

  // Clamp the configured count to 1 .. EffMax
  always_comb begin
    if (cfg_i.sample_count == '0) begin
      n_eff = aasv_pkg::CNT_W'(1);
    end else if (cfg_i.sample_count > aasv_pkg::CNT_W'(EffMax)) begin
      n_eff = aasv_pkg::CNT_W'(EffMax);
    end else begin
      n_eff = cfg_i.sample_count;
    end
  end

  // Next sample closes the run once the count is reached or passed
  always_comb begin
    seen_inc = {1'b0, seen_q} + (aasv_pkg::CNT_W + 1)'(1);
    closes   = seen_inc >= {1'b0, n_eff};
    sum_add  = sum_q + SumW'($signed(raw_code_i));
  end

  // Hold a closing sample until the converter is free
  assign in_ready_o = ~closes | conv_idle_i;
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    sum_d  = sum_q;
    seen_d = seen_q;
    if (accept) begin
      if (closes) begin
        sum_d  = '0;
        seen_d = '0;
      end else begin
        sum_d  = sum_add;
        seen_d = seen_inc[aasv_pkg::CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      seen_q <= '0;
    end else begin
      sum_q  <= sum_d;
      seen_q <= seen_d;
    end
  end

  // Hand the closed run to the converter in the transfer cycle
  always_comb begin
    job_o.valid = accept & closes;
    job_o.sum   = aasv_pkg::JOB_SUM_W'(sum_add);
    job_o.count = n_eff;
    job_o.shift = aasv_pkg::shift_amount(cfg_i.resolution_bits);
    job_o.gain  = cfg_i.gain_exponent;
  end

endmodule

### rtl/core/aasv_convert.sv
// Converter: signed mean, resolution shift, voltage scaling with rounding.
// Depends on aasv_pkg, aasv_serial_div and aasv_serial_mul.
module aasv_convert (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  aasv_pkg::job_t job_i,
  output logic           idle_o,
  output aasv_pkg::res_t res_o,
  input  logic           res_ready_i
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DIV1   = 3'd1;
  localparam logic [2:0] ST_MEAN   = 3'd2;
  localparam logic [2:0] ST_RED    = 3'd3;
  localparam logic [2:0] ST_MSTART = 3'd4;
  localparam logic [2:0] ST_MUL    = 3'd5;
  localparam logic [2:0] ST_DIV2   = 3'd6;
  localparam logic [2:0] ST_DONE   = 3'd7;

  localparam int RED_W  = aasv_pkg::RED_W;
  localparam int VOLT_W = aasv_pkg::VOLT_W;
  localparam int NUM_W  = aasv_pkg::NUM_W;
  localparam int DEN_W  = aasv_pkg::DEN_W;
  localparam int SUM_W  = aasv_pkg::JOB_SUM_W;

  logic [2:0]                     state_q, state_d;
  logic                           neg_q;
  logic [aasv_pkg::SHIFT_W-1:0]   shift_q;
  logic [aasv_pkg::GAIN_W-1:0]    gain_q;
  // Mean and reduced code keep the full sum width: a count lowered mid-run
  // can push them past the code width, and only the low bits leave
  logic signed [SUM_W-1:0]        mean_q;
  logic signed [SUM_W-1:0]        red_q;
  logic signed [VOLT_W-1:0]       volt_q;

  logic [SUM_W-1:0]               sum_mag;
  logic [SUM_W-1:0]               mean_mag;
  logic [SUM_W-1:0]               red_mag;
  logic [VOLT_W-1:0]              volt_mag;
  logic [aasv_pkg::SHIFT_W-1:0]   scale_sh;

  logic                           div_start;
  logic [NUM_W-1:0]               div_dividend;
  logic [DEN_W-1:0]               div_divisor;
  logic                           div_done;
  logic [NUM_W-1:0]               div_quo;
  logic                           div_rem_nz;

  logic                           mul_start;
  logic [NUM_W-1:0]               mul_mcand;
  logic [NUM_W-1:0]               mul_init;
  logic                           mul_done;
  logic [NUM_W-1:0]               mul_prod;

  // Magnitudes of the incoming sum, the mean, the reduced code and the voltage, and the scale shift
  always_comb begin
    sum_mag  = job_i.sum[SUM_W-1] ? SUM_W'(-job_i.sum) : SUM_W'(job_i.sum);
    mean_mag = div_quo[SUM_W-1:0] + SUM_W'(neg_q & div_rem_nz);
    red_mag  = red_q[SUM_W-1] ? SUM_W'(-red_q) : SUM_W'(red_q);
    volt_mag = div_quo[VOLT_W-1:0];
    scale_sh = shift_q + aasv_pkg::SHIFT_W'(1);
  end

  // Sequence the shared divider and the multiplier
  always_comb begin
    state_d      = state_q;
    div_start    = 1'b0;
    div_dividend = NUM_W'(sum_mag);
    div_divisor  = DEN_W'(job_i.count);
    mul_start    = 1'b0;
    mul_mcand    = NUM_W'(red_mag) << scale_sh;
    mul_init     = NUM_W'(aasv_pkg::VOLT_HALF) << gain_q;
    case (state_q)
      ST_IDLE: begin
        if (job_i.valid) begin
          div_start = 1'b1;
          state_d   = ST_DIV1;
        end
      end
      ST_DIV1: begin
        if (div_done) begin
          state_d = ST_MEAN;
        end
      end
      ST_MEAN:   state_d = ST_RED;
      ST_RED:    state_d = ST_MSTART;
      ST_MSTART: begin
        mul_start = 1'b1;
        state_d   = ST_MUL;
      end
      ST_MUL: begin
        div_dividend = mul_prod;
        div_divisor  = DEN_W'(aasv_pkg::VOLT_DEN) << gain_q;
        if (mul_done) begin
          div_start = 1'b1;
          state_d   = ST_DIV2;
        end
      end
      ST_DIV2: begin
        if (div_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Capture the run settings, then the mean, reduced code and voltage
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && job_i.valid) begin
      neg_q   <= job_i.sum[SUM_W-1];
      shift_q <= job_i.shift;
      gain_q  <= job_i.gain;
    end
    if (state_q == ST_MEAN) begin
      mean_q <= neg_q ? -$signed(mean_mag) : $signed(mean_mag);
    end
    if (state_q == ST_RED) begin
      red_q <= mean_q >>> shift_q;
    end
    if (state_q == ST_DIV2 && div_done) begin
      volt_q <= red_q[SUM_W-1] ? -$signed(volt_mag) : $signed(volt_mag);
    end
  end

  aasv_serial_div #(
    .DvdW (NUM_W),
    .DvsW (DEN_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo),
    .rem_nz_o   (div_rem_nz)
  );

  aasv_serial_mul #(
    .ProdW (NUM_W),
    .CoefW (aasv_pkg::COEF_W),
    .Coef  (aasv_pkg::VOLT_COEF)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .mcand_i (mul_mcand),
    .init_i  (mul_init),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  assign idle_o        = (state_q == ST_IDLE);
  assign res_o.valid   = (state_q == ST_DONE);
  assign res_o.reduced = red_q[RED_W-1:0];
  assign res_o.voltage = volt_q;

endmodule

### rtl/core/adc_average_scale_to_voltage.sv
// Top level of the converter-code averager with voltage scaling.
// Depends on aasv_pkg, the channel interfaces, aasv_accum and aasv_convert.
//
// Usage:
//   in_chan_i  takes one 24-bit two's-complement code per transfer.
//   res_chan_o offers one result per closed run: the floor of the signed mean
//              shifted down to the kept resolution, and the voltage (LSB 2^-24 V).
//   cfg_chan_i writes sample_count (0), resolution_bits (1), gain_exponent (2);
//              it is always ready; the user writes it only while no run converts,
//              which the block itself does not enforce.
// Sample flow and conversion:
//   Samples that do not close a run stream back to back, also while an
//   earlier run is still converting. The closing sample starts a bit-serial
//   conversion: the 50-step mean divide, the rounding of the mean, the shift,
//   the start and the 14 steps of the multiply, the divide by the gain-scaled
//   denominator and the load of the output register. A closing sample waits
//   (ready low) until the converter is free.
// Reset clears the sum, the sample count and the output valid flag; the
// registers return to 1, 24 and 0. When the receiver stalls, the result holds
// in the output register and the converter holds the next one behind it.
module adc_average_scale_to_voltage #(
  parameter int MaxSamples = aasv_pkg::MAX_SAMPLES
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  aasv_in_if.sink   in_chan_i,
  aasv_out_if.source res_chan_o,
  aasv_cfg_if.sink  cfg_chan_i
);

  aasv_pkg::cfg_t   cfg_q;
  aasv_pkg::job_t   job;
  aasv_pkg::res_t   res;
  logic             conv_idle;
  logic             res_ready;

  logic                               out_valid_q;
  logic signed [aasv_pkg::RED_W-1:0]  out_red_q;
  logic signed [aasv_pkg::VOLT_W-1:0] out_volt_q;

  // Take register writes at any time
  assign cfg_chan_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_count    <= aasv_pkg::SAMPLE_COUNT_RST;
      cfg_q.resolution_bits <= aasv_pkg::RESOLUTION_RST;
      cfg_q.gain_exponent   <= aasv_pkg::GAIN_RST;
    end else if (cfg_chan_i.valid) begin
      case (cfg_chan_i.index)
        aasv_pkg::REG_SAMPLE_COUNT: begin
          cfg_q.sample_count <= cfg_chan_i.data[aasv_pkg::CNT_W-1:0];
        end
        aasv_pkg::REG_RESOLUTION: begin
          cfg_q.resolution_bits <= cfg_chan_i.data[aasv_pkg::RES_W-1:0];
        end
        aasv_pkg::REG_GAIN: begin
          cfg_q.gain_exponent <= cfg_chan_i.data[aasv_pkg::GAIN_W-1:0];
        end
        default: ;
      endcase
    end
  end

  aasv_accum #(
    .MaxSamples (MaxSamples)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_chan_i.valid),
    .raw_code_i  (in_chan_i.raw_code),
    .in_ready_o  (in_chan_i.ready),
    .cfg_i       (cfg_q),
    .conv_idle_i (conv_idle),
    .job_o       (job)
  );

  aasv_convert u_convert (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job),
    .idle_o      (conv_idle),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  // Load the output register when it is empty or being drained
  assign res_ready = ~out_valid_q | res_chan_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res.valid) begin
      out_red_q  <= res.reduced;
      out_volt_q <= res.voltage;
    end
  end

  assign res_chan_o.valid         = out_valid_q;
  assign res_chan_o.reduced_code  = out_red_q;
  assign res_chan_o.voltage_fixed = out_volt_q;

endmodule

### rtl/core/aasv_checker.sv
// Port-level checks of the averager result channel, bound to the top level.
// Depends on aasv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module aasv_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               res_valid_i,
  input logic                               res_ready_i,
  input logic signed [aasv_pkg::RED_W-1:0]  reduced_i,
  input logic signed [aasv_pkg::VOLT_W-1:0] voltage_i
);

  // Hold a stalled result until its transfer
  `AASV_ASSERT_NEXT(a_valid_holds, clk_i, rst_ni, res_valid_i && !res_ready_i, res_valid_i, "result dropped while stalled")

  `AASV_ASSERT_NEXT(a_payload_holds, clk_i, rst_ni, res_valid_i && !res_ready_i, $stable(reduced_i) && $stable(voltage_i), "result changed while stalled")

  // Keep the result valid free of unknowns, and the payload while valid
  `AASV_ASSERT_NOW(a_valid_known, clk_i, rst_ni, 1'b1, !$isunknown(res_valid_i), "result valid unknown")

  `AASV_ASSERT_NOW(a_payload_known, clk_i, rst_ni, res_valid_i, !$isunknown({reduced_i, voltage_i}), "payload unknown")

endmodule

bind adc_average_scale_to_voltage aasv_checker u_aasv_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_chan_o.valid),
  .res_ready_i (res_chan_o.ready),
  .reduced_i   (res_chan_o.reduced_code),
  .voltage_i   (res_chan_o.voltage_fixed)
);
